>>> src/lfu_pkg.sv
// ---------------------------------------------------------------------------
// lfu_pkg
// Shared types, codes and bus widths for the LFU sorted entry table.
// ---------------------------------------------------------------------------
package lfu_pkg;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 72;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_EVICT  = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_ACCESS = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BUDGET  = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] cnt;
        logic [31:0] size;
    } t_entry;

endpackage

>>> src/lfu_cell.sv
// ---------------------------------------------------------------------------
// lfu_cell
// One table slot: holds an entry and takes its neighbor's entry on shift.
// ---------------------------------------------------------------------------
module lfu_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  lfu_pkg::t_entry i_entry,
    output lfu_pkg::t_entry o_entry
);
    import lfu_pkg::*;

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

>>> src/lfu_sorted_entry_table.sv
// ---------------------------------------------------------------------------
// lfu_sorted_entry_table
// Use-count ordered table of cached elements with a total size budget.
// ---------------------------------------------------------------------------
// Input items arrive on s_axis (opcode, element id, element size); one
// result item per input leaves on m_axis (status, evicted id, total used).
// The budget register is written through i_cfg_wr_en / i_cfg_wr_data.
// The table is a ring of ENTRIES cells that rotates through a head unit
// once per pass; the head rewrites each entry as it goes by.
// Path from the accepting edge to m_axis_tvalid high:
//   rejected add or evict of an empty table: straight to the result
//   add, evict, remove, access of a missing id: a scan pass
//   access: find pass, then reorder pass
// One item is in work at a time; s_axis_tready is high while idle, from
// the cycle after the result is loaded.
// A finished result sits in the output register; the next item is
// accepted meanwhile, and its result waits until the register is taken.
// Reset (synchronous, active low) empties the table, zeroes the total
// and the budget, and drops any pending result.
// ---------------------------------------------------------------------------
module lfu_sorted_entry_table #(
    parameter int ENTRIES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [31:0]                     i_cfg_wr_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // opcode[1:0], element_id[33:2], element_size[65:34], zero pad
    input  logic [lfu_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // status[1:0], evicted_id[33:2], total_used[65:34], zero pad
    output logic [lfu_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import lfu_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_BUMP = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state          r_state;
    logic [31:0]     r_budget;
    logic [CW-1:0]   r_count;
    logic [31:0]     r_used;
    logic [31:0]     r_evicted;
    logic [1:0]      r_op;
    logic [1:0]      r_status;
    logic [IW-1:0]   r_t;
    logic [IW-1:0]   r_m;
    logic            r_found;
    t_entry          r_key;
    t_entry          r_hold;
    logic            r_ovalid;
    logic [1:0]      r_ostatus;
    logic [31:0]     r_oevicted;
    logic [31:0]     r_oused;

    t_entry          w_cell [ENTRIES];
    t_entry          w_wr;
    t_entry          w_head;
    t_entry          w_next;
    logic            w_shift;
    logic            w_in_range;
    logic            w_match;
    logic            w_last;
    logic            w_ins;
    logic [32:0]     w_sum;
    logic [1:0]      w_in_op;
    logic [31:0]     w_in_id;
    logic [31:0]     w_in_size;

    assign w_in_op   = s_axis_tdata[1:0];
    assign w_in_id   = s_axis_tdata[33:2];
    assign w_in_size = s_axis_tdata[65:34];

    assign w_shift = (r_state == S_SCAN) || (r_state == S_BUMP);

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
            t_entry w_src;
            if (gi == ENTRIES - 1) begin : g_tail
                assign w_src = w_wr;
            end else begin : g_mid
                assign w_src = w_cell[gi + 1];
            end
            lfu_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_entry (w_src),
                .o_entry (w_cell[gi])
            );
        end
    endgenerate

    assign w_head     = w_cell[0];
    assign w_next     = w_cell[1];
    assign w_in_range = CW'(r_t) < r_count;
    assign w_match    = !r_found && w_in_range && (w_head.id == r_key.id);
    assign w_last     = (r_t == IW'(ENTRIES - 1));
    assign w_ins      = !r_found && ((r_t == r_m) || (w_head.cnt < r_key.cnt));
    assign w_sum      = {1'b0, r_used} + {1'b0, w_in_size};

    always_comb begin
        w_wr = w_head;
        case (r_state)
            S_SCAN: begin
                if (r_op == OP_ADD && CW'(r_t) == r_count) begin
                    w_wr = r_key;
                end else if (r_op == OP_REMOVE && (r_found || w_match)) begin
                    w_wr = w_next;
                end
            end
            S_BUMP: begin
                if (w_ins) begin
                    w_wr = r_key;
                end else if (r_found && r_t <= r_m) begin
                    w_wr = r_hold;
                end
            end
            default: w_wr = w_head;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_budget <= '0;
            r_count  <= '0;
            r_used   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_budget <= i_cfg_wr_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op      <= w_in_op;
                        r_key     <= '{id: w_in_id, cnt: 32'd1, size: w_in_size};
                        r_t       <= '0;
                        r_found   <= 1'b0;
                        r_evicted <= '0;
                        case (w_in_op)
                            OP_ADD: begin
                                if (w_sum > {1'b0, r_budget}) begin
                                    r_status <= ST_BUDGET;
                                    r_state  <= S_DONE;
                                end else if (r_count == CW'(ENTRIES)) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= ST_OK;
                                    r_state  <= S_SCAN;
                                end
                            end
                            OP_EVICT: begin
                                if (r_count == '0) begin
                                    r_status <= ST_MISSING;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= ST_OK;
                                    r_state  <= S_SCAN;
                                end
                            end
                            default: begin
                                r_status <= ST_MISSING;
                                r_state  <= S_SCAN;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_t    <= w_last ? '0 : r_t + IW'(1);
                    r_hold <= w_head;
                    case (r_op)
                        OP_ADD: begin
                            if (w_last) begin
                                r_count <= r_count + CW'(1);
                                r_used  <= r_used + r_key.size;
                            end
                        end
                        OP_EVICT: begin
                            if (CW'(r_t) == r_count - CW'(1)) begin
                                r_evicted <= w_head.id;
                                r_used    <= r_used - w_head.size;
                            end
                            if (w_last) begin
                                r_count <= r_count - CW'(1);
                            end
                        end
                        OP_REMOVE: begin
                            if (w_match) begin
                                r_found  <= 1'b1;
                                r_status <= ST_OK;
                                r_used   <= r_used - w_head.size;
                            end
                            if (w_last && (r_found || w_match)) begin
                                r_count <= r_count - CW'(1);
                            end
                        end
                        default: begin
                            if (w_last) begin
                                r_found <= 1'b0;
                            end else if (w_match) begin
                                r_found <= 1'b1;
                            end
                            if (w_match) begin
                                r_status <= ST_OK;
                                r_m      <= r_t;
                                r_key    <= '{id: w_head.id,
                                              cnt: (&w_head.cnt) ? w_head.cnt
                                                                 : w_head.cnt + 32'd1,
                                              size: w_head.size};
                            end
                        end
                    endcase
                    if (w_last) begin
                        if (r_op == OP_ACCESS) begin
                            r_state <= (r_found || w_match) ? S_BUMP : S_DONE;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_BUMP: begin
                    r_t    <= w_last ? '0 : r_t + IW'(1);
                    r_hold <= w_head;
                    if (w_ins) begin
                        r_found <= 1'b1;
                    end
                    if (w_last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid   <= 1'b1;
                        r_ostatus  <= r_status;
                        r_oevicted <= r_evicted;
                        r_oused    <= r_used;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'b0, r_oused, r_oevicted, r_ostatus};

endmodule

>>> src/lfu_checker.sv
// ---------------------------------------------------------------------------
// lfu_checker
// Port-level checks for the LFU sorted entry table, bound to the top level.
// ---------------------------------------------------------------------------
module lfu_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            i_s_tready,
    input logic                            i_m_tvalid,
    input logic                            i_m_tready,
    input logic [lfu_pkg::OUT_TDATA_W-1:0] i_m_tdata
);
    import lfu_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("result item changed while stalled");

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("second item taken while one is in work");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid && i_s_tready)
        else $error("block not idle after reset");

    a_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (i_m_tdata[1:0] != ST_OK) |-> (i_m_tdata[33:2] == 32'd0))
        else $error("evicted id set on a failed operation");

endmodule

bind lfu_sorted_entry_table lfu_checker u_lfu_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);
